/* hdl/urfd_pkg.sv */
// Shared types and constants of the UART receive FIFO frame deframer.
// Depends on nothing; the top level, front end, back end and testbench import it.
`default_nettype none

package urfd_pkg;

  localparam logic [7:0]  SyncStart  = 8'hAA;
  localparam logic [7:0]  SyncEnd    = 8'h55;
  localparam int unsigned FrameLen   = 10;
  localparam int unsigned PayloadLen = 8;
  localparam int unsigned FposW      = 4;
  localparam int unsigned SlotW      = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [PayloadLen-1:0] payload_t;

  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    logic rd_en;
    logic cmd_pop;
  } back_ctrl_t;

endpackage

`default_nettype wire

/* hdl/uart_rx_fifo_frame_deframer.sv */
// UART receive FIFO with sync-byte frame deframer, top level.
// A tick drains the bytes buffered before it (up to FIFO_DEPTH - 1) through the
// one-read-per-cycle memory port, then loads its result once the output register is free.
// Up to two ticks queue, the oldest draining; the result waits in an output register.
// Reset clears pointers, frame position, tick queue and result flag; memories are not cleared.
// Depends on urfd_pkg, urfd_front and urfd_back.
`default_nettype none

module uart_rx_fifo_frame_deframer #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       opcode_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      payload_0_o,
  output logic [7:0]      payload_1_o,
  output logic [7:0]      payload_2_o,
  output logic [7:0]      payload_3_o,
  output logic [7:0]      payload_4_o,
  output logic [7:0]      payload_5_o,
  output logic [7:0]      payload_6_o,
  output logic [7:0]      payload_7_o
);
  import urfd_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);

  back_ctrl_t      ctrl;
  logic [PtrW-1:0] rd_ptr;
  byte_t           rd_data;
  logic            cmd_valid;
  logic [PtrW-1:0] cmd_snap;
  payload_t        payload;

  urfd_front #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PtrW       (PtrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .ctrl_i      (ctrl),
    .rd_ptr_i    (rd_ptr),
    .rd_data_o   (rd_data),
    .cmd_valid_o (cmd_valid),
    .cmd_snap_o  (cmd_snap)
  );

  urfd_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PtrW       (PtrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_snap_i  (cmd_snap),
    .rd_data_i   (rd_data),
    .ctrl_o      (ctrl),
    .rd_ptr_o    (rd_ptr),
    .empty       (empty),
    .pop         (pop),
    .payload_o   (payload)
  );

  assign payload_0_o = payload[0];
  assign payload_1_o = payload[1];
  assign payload_2_o = payload[2];
  assign payload_3_o = payload[3];
  assign payload_4_o = payload[4];
  assign payload_5_o = payload[5];
  assign payload_6_o = payload[6];
  assign payload_7_o = payload[7];

endmodule

`default_nettype wire

/* hdl/urfd_front.sv */
// Front end: accepts items, writes bytes into the ring memory, queues ticks.
// Depends on urfd_pkg.
`default_nettype none

module urfd_front #(
  parameter int FIFO_DEPTH = 64,
  parameter int PtrW       = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 opcode_i,
  input  wire urfd_pkg::byte_t      rx_byte_i,
  input  wire urfd_pkg::back_ctrl_t ctrl_i,
  input  wire logic [PtrW-1:0]      rd_ptr_i,
  output urfd_pkg::byte_t           rd_data_o,
  output logic                      cmd_valid_o,
  output logic [PtrW-1:0]           cmd_snap_o
);
  import urfd_pkg::*;

  localparam logic [PtrW-1:0] LastIdx = PtrW'(FIFO_DEPTH - 1);

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  byte_t           mem [FIFO_DEPTH];
  byte_t           rd_data_q;
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] lrd_q, lrd_d;
  logic [PtrW-1:0] snap_q [2];
  logic            head_q, head_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [PtrW-1:0] wr_nxt;
  logic            accept, is_tick, byte_wr, cmd_push;
  logic            tail;

  assign wr_nxt   = next_ptr(wr_q);
  assign is_tick  = (opcode_i == OpTick);
  assign full     = (cnt_q == 2'd2) || ((wr_nxt == rd_ptr_i) && (rd_ptr_i != lrd_q));
  assign accept   = push && !full;
  assign byte_wr  = accept && !is_tick && (wr_nxt != lrd_q);
  assign cmd_push = accept && is_tick;
  assign tail     = head_q ^ cnt_q[0];

  always_comb begin
    wr_d   = byte_wr ? wr_nxt : wr_q;
    lrd_d  = cmd_push ? wr_q : lrd_q;
    head_d = ctrl_i.cmd_pop ? ~head_q : head_q;
    cnt_d  = cnt_q + {1'b0, cmd_push} - {1'b0, ctrl_i.cmd_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      lrd_q  <= '0;
      head_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wr_q   <= wr_d;
      lrd_q  <= lrd_d;
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_push) begin
      snap_q[tail] <= wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_wr) begin
      mem[wr_q] <= rx_byte_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_ptr_i];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_snap_o  = snap_q[head_q];

endmodule

`default_nettype wire

/* hdl/urfd_back.sv */
// Back end: drains the ring memory per tick, deframes bytes, holds the result.
// Depends on urfd_pkg.
`default_nettype none

module urfd_back #(
  parameter int FIFO_DEPTH = 64,
  parameter int PtrW       = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire logic [PtrW-1:0]      cmd_snap_i,
  input  wire urfd_pkg::byte_t      rd_data_i,
  output urfd_pkg::back_ctrl_t      ctrl_o,
  output logic [PtrW-1:0]           rd_ptr_o,
  output logic                      empty,
  input  wire logic                 pop,
  output urfd_pkg::payload_t        payload_o
);
  import urfd_pkg::*;

  localparam logic [PtrW-1:0]  LastIdx = PtrW'(FIFO_DEPTH - 1);
  localparam logic [FposW-1:0] LastPos = FposW'(FrameLen - 1);

  logic [PtrW-1:0]  rp_q, rp_d;
  logic             rdv_q;
  logic [FposW-1:0] fpos_q, fpos_d;
  byte_t            frame_q [PayloadLen];
  payload_t         acc_q, acc_d;
  payload_t         out_q;
  logic             out_valid_q, out_valid_d;
  logic             rd_en, done, found, frame_wr;
  logic [SlotW-1:0] slot;

  assign rd_en    = cmd_valid_i && (rp_q != cmd_snap_i);
  assign done     = cmd_valid_i && (rp_q == cmd_snap_i) && !rdv_q && (!out_valid_q || pop);
  assign found    = rdv_q && (fpos_q == LastPos) && (rd_data_i == SyncEnd);
  assign frame_wr = rdv_q && (fpos_q != '0) && (fpos_q != LastPos);
  assign slot     = SlotW'(fpos_q - FposW'(1));

  always_comb begin
    rp_d = rd_en ? ((rp_q == LastIdx) ? '0 : rp_q + PtrW'(1)) : rp_q;
    fpos_d = fpos_q;
    if (rdv_q) begin
      if (fpos_q == '0) begin
        fpos_d = (rd_data_i == SyncStart) ? FposW'(1) : '0;
      end else if (fpos_q == LastPos) begin
        fpos_d = '0;
      end else begin
        fpos_d = fpos_q + FposW'(1);
      end
    end
    acc_d = acc_q;
    if (done) begin
      acc_d = '0;
    end else if (found) begin
      for (int i = 0; i < PayloadLen; i++) begin
        acc_d[i] = frame_q[i];
      end
    end
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      rdv_q       <= 1'b0;
      fpos_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      rdv_q       <= rd_en;
      fpos_q      <= fpos_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_wr) begin
      frame_q[slot] <= rd_data_i;
    end
    if (done) begin
      out_q <= acc_q;
    end
  end

  assign ctrl_o.rd_en   = rd_en;
  assign ctrl_o.cmd_pop = done;
  assign rd_ptr_o       = rp_q;
  assign empty          = !out_valid_q;
  assign payload_o      = out_q;

endmodule

`default_nettype wire

/* hdl/urfd_checker.sv */
// Port-level checks for the deframer top level, bound to it below.
// Depends on the top level's ports only.
`default_nettype none

module urfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       opcode_i,
  input wire logic [7:0] rx_byte_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] payload_0_o,
  input wire logic [7:0] payload_1_o,
  input wire logic [7:0] payload_2_o,
  input wire logic [7:0] payload_3_o,
  input wire logic [7:0] payload_4_o,
  input wire logic [7:0] payload_5_o,
  input wire logic [7:0] payload_6_o,
  input wire logic [7:0] payload_7_o
);

  logic [2:0] pend_q;
  logic       tick_in, res_out;

  assign tick_in = push && !full && opcode_i;
  assign res_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, tick_in} - {2'b00, res_out};
    end
  end

  a_no_result_without_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 3'd0) |-> empty)
    else $error("result shown without a pending tick");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more ticks pending than the design can hold");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

  a_payload_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(payload_0_o) && $stable(payload_3_o)
                          && $stable(payload_7_o)))
    else $error("payload changed while waiting for transfer");

endmodule

bind uart_rx_fifo_frame_deframer urfd_checker u_checker (.*);

`default_nettype wire

/* test/tb_uart_rx_fifo_frame_deframer.sv */
// Testbench for uart_rx_fifo_frame_deframer: a directed table, then random frame traffic,
// with every popped result checked field by field against the table or an in-bench model.
// Depends on urfd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_uart_rx_fifo_frame_deframer;
  import urfd_pkg::*;

  localparam int unsigned FifoDepth = 64;
  localparam int unsigned Limit     = 1_000_000;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned DrainWait = 2 * FifoDepth;

  typedef struct {
    op_e      op;
    byte_t    data;
    bit       typed;
    payload_t want;
  } stim_row_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic       opcode_i  = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] payload_0_o, payload_1_o, payload_2_o, payload_3_o;
  logic [7:0] payload_4_o, payload_5_o, payload_6_o, payload_7_o;

  payload_t    payload_due [$];
  stim_row_t   stim_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  bit          idle_on        = 1'b1;
  bit          hold_rx        = 1'b0;

  byte_t       ring_mem [FifoDepth];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;
  byte_t       frame_buf [FrameLen];
  int unsigned frame_pos = 0;

  uart_rx_fifo_frame_deframer #(
    .FIFO_DEPTH(FifoDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .opcode_i   (opcode_i),
    .rx_byte_i  (rx_byte_i),
    .empty      (empty),
    .pop        (pop),
    .payload_0_o(payload_0_o),
    .payload_1_o(payload_1_o),
    .payload_2_o(payload_2_o),
    .payload_3_o(payload_3_o),
    .payload_4_o(payload_4_o),
    .payload_5_o(payload_5_o),
    .payload_6_o(payload_6_o),
    .payload_7_o(payload_7_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("** uart_rx_fifo_frame_deframer: FAILED **");
      $finish;
    end
  end

  function automatic bit deframe_predict(op_e op, byte_t data, output payload_t res);
    int unsigned nxt;
    byte_t       b;
    res = '0;
    if (op == OpByte) begin
      nxt = (ring_wr + 1) % FifoDepth;
      if (nxt != ring_rd) begin
        ring_mem[ring_wr] = data;
        ring_wr = nxt;
      end
      return 1'b0;
    end
    while (ring_rd != ring_wr) begin
      b = ring_mem[ring_rd];
      ring_rd = (ring_rd + 1) % FifoDepth;
      if (frame_pos == 0 && b != SyncStart) continue;
      frame_buf[frame_pos] = b;
      frame_pos++;
      if (frame_pos == FrameLen) begin
        if (frame_buf[FrameLen-1] == SyncEnd) begin
          for (int i = 0; i < PayloadLen; i++) res[i] = frame_buf[i+1];
        end
        frame_pos = 0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    payload_t got;
    payload_t want;
    if (rst_ni && pop && !empty) begin
      got = {payload_7_o, payload_6_o, payload_5_o, payload_4_o,
             payload_3_o, payload_2_o, payload_1_o, payload_0_o};
      if (payload_due.size() == 0) begin
        report_mismatch("result with none due, payload_0", got[0], 0);
      end else begin
        want = payload_due.pop_front();
        for (int i = 0; i < PayloadLen; i++) begin
          if (got[i] !== want[i]) report_mismatch($sformatf("payload_%0d", i), got[i], want[i]);
        end
      end
    end
  end

  task automatic send_item(op_e op, byte_t data, bit typed = 1'b0, payload_t want = '0);
    payload_t res;
    if (idle_on && $urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push      <= 1'b1;
    opcode_i  <= op;
    rx_byte_i <= data;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (deframe_predict(op, data, res)) payload_due.push_back(typed ? want : res);
  endtask

  function automatic stim_row_t row(op_e op, byte_t data, bit typed = 1'b0,
                                    payload_t want = '0);
    stim_row_t r;
    r.op    = op;
    r.data  = data;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic byte_t frame_byte();
    int unsigned k;
    k = $urandom_range(0, 9);
    return (k == 0) ? SyncStart : (k == 1) ? SyncEnd : byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(byte_t data);
    send_item(OpByte, data);
    if ($urandom_range(0, 24) == 0) send_item(OpTick, byte_t'($urandom_range(0, 255)));
  endtask

  task automatic send_traffic(int unsigned n_items, int unsigned tick_pct);
    int unsigned start_cnt;
    int unsigned kind;
    int unsigned len;
    byte_t       last;
    start_cnt = items_sent;
    while (items_sent - start_cnt < n_items) begin
      if (idle_on && $urandom_range(0, 15) == 0) begin
        tx_idle_pct = $urandom_range(0, 3) * 15;
        rx_idle_pct = $urandom_range(0, 3) * 15;
      end
      kind = $urandom_range(0, 99);
      if (kind < 58) begin
        send_byte(SyncStart);
        repeat (PayloadLen) send_byte(frame_byte());
        send_byte(SyncEnd);
      end else if (kind < 73) begin
        send_byte(SyncStart);
        len = $urandom_range(1, PayloadLen);
        repeat (len) send_byte(frame_byte());
        if (len == PayloadLen) begin
          last = byte_t'($urandom_range(0, 255));
          send_byte((last == SyncEnd) ? ~last : last);
        end
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(FifoDepth, FifoDepth + 12);
        for (int i = 0; i < len; i++) begin
          send_item(OpByte, (i % FrameLen == 0) ? SyncStart : frame_byte());
        end
      end
      if ($urandom_range(0, 99) < tick_pct) send_item(OpTick, byte_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < rx_idle_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    // typed payloads list byte 7 first
    stim_rows.push_back(row(OpTick, 8'h00, 1'b1, '0));
    stim_rows.push_back(row(OpByte, 8'h00));
    stim_rows.push_back(row(OpByte, 8'hFF));
    stim_rows.push_back(row(OpTick, 8'hFF, 1'b1, '0));
    stim_rows.push_back(row(OpByte, SyncStart));
    stim_rows.push_back(row(OpByte, 8'h00));
    stim_rows.push_back(row(OpByte, 8'hFF));
    stim_rows.push_back(row(OpByte, 8'h80));
    stim_rows.push_back(row(OpByte, 8'h7F));
    stim_rows.push_back(row(OpByte, 8'h01));
    stim_rows.push_back(row(OpByte, 8'hFE));
    stim_rows.push_back(row(OpByte, 8'hAA));
    stim_rows.push_back(row(OpByte, 8'h55));
    stim_rows.push_back(row(OpByte, SyncEnd));
    stim_rows.push_back(row(OpTick, 8'h00, 1'b1,
                            {8'h55, 8'hAA, 8'hFE, 8'h01, 8'h7F, 8'h80, 8'hFF, 8'h00}));
    stim_rows.push_back(row(OpByte, SyncStart));
    stim_rows.push_back(row(OpByte, 8'h11));
    stim_rows.push_back(row(OpByte, 8'h22));
    stim_rows.push_back(row(OpByte, 8'h33));
    stim_rows.push_back(row(OpByte, 8'h44));
    stim_rows.push_back(row(OpByte, 8'h55));
    stim_rows.push_back(row(OpByte, 8'h66));
    stim_rows.push_back(row(OpByte, 8'h77));
    stim_rows.push_back(row(OpByte, 8'h88));
    stim_rows.push_back(row(OpByte, 8'h00));
    stim_rows.push_back(row(OpTick, 8'hA5, 1'b1, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 15;
    rx_idle_pct = 15;
    foreach (stim_rows[i]) send_item(stim_rows[i].op, stim_rows[i].data,
                                     stim_rows[i].typed, stim_rows[i].want);

    send_traffic(800, 50);

    hold_rx = 1'b1;
    repeat (6) send_item(OpTick, byte_t'($urandom_range(0, 255)));
    send_traffic(80, 90);

    push <= 1'b0;
    while (payload_due.size() != 0) @(posedge clk_i);

    send_traffic(700, 40);

    idle_on = 1'b0;
    send_traffic(300, 50);
    send_item(OpTick, 8'h00);

    push <= 1'b0;
    while (payload_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** uart_rx_fifo_frame_deframer: PASSED **");
    end else begin
      $display("** uart_rx_fifo_frame_deframer: FAILED **");
    end
    $finish;
  end

endmodule
